// ----- hdl/assert_macros.svh -----
// Assertion macros for the checker file of the hasher.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, switched off while reset is held low
`define XXH_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that also runs through reset
`define XXH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/xxh_pkg.sv -----
// Package for the XXH64 stream hasher: primes, lane start values, rotate helper,
// datapath operation codes, controller states and the command/status structs.
// Depends on nothing.
`default_nettype none

package xxh_pkg;

    localparam logic [63:0] C_P1 = 64'h9E3779B185EBCA87;
    localparam logic [63:0] C_P2 = 64'hC2B2AE3D27D4EB4F;
    localparam logic [63:0] C_P3 = 64'h165667B19E3779F9;
    localparam logic [63:0] C_P4 = 64'h85EBCA77C2B2AE63;
    localparam logic [63:0] C_P5 = 64'h27D4EB2F165667C5;

    // Lane start values for seed zero
    localparam logic [63:0] C_LANE0_INIT = C_P1 + C_P2;
    localparam logic [63:0] C_LANE1_INIT = C_P2;
    localparam logic [63:0] C_LANE2_INIT = 64'h0;
    localparam logic [63:0] C_LANE3_INIT = 64'h0 - C_P1;

    localparam int C_ROT_ROUND  = 31;
    localparam int C_ROT_HELD   = 27;
    localparam int C_ROT_QUAD   = 23;
    localparam int C_ROT_SINGLE = 11;
    localparam int C_SHR_AV1    = 33;
    localparam int C_SHR_AV2    = 29;
    localparam int C_SHR_AV3    = 32;

    localparam logic [3:0] C_WORD_BYTES = 4'd8;
    localparam logic [3:0] C_QUAD_BYTES = 4'd4;
    localparam logic [1:0] C_HELD_MAX   = 2'd3;
    localparam logic [2:0] C_LAST_LANE  = 3'd3;

    // Datapath operations; the OP_M_ ones run through the shared multiplier
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,     // latch input word, count and last flag; add to length
        OP_HOLD,     // hold the word, bump held count, drop tail count
        OP_SCLR,     // stripe done: drop held words and tail count
        OP_H_CONV,   // h = rotl(lane0, 1)
        OP_H_ADDL,   // h += rotl(lane[sel], converge shift)
        OP_H_P5,     // h = prime 5
        OP_H_TOTAL,  // h += total length
        OP_EMIT,     // publish digest, return state to reset values
        OP_M_WP2,    // t = word(sel) * P2
        OP_M_LANE,   // lane[sel] = rotl(lane[sel] + t, 31) * P1
        OP_M_LP2,    // t = lane[sel] * P2
        OP_M_TR,     // t = rotl(t, 31) * P1
        OP_M_MERGE,  // h = (h ^ t) * P1 + P4
        OP_M_HELD,   // h = rotl(h ^ t, 27) * P1 + P4
        OP_M_W32,    // t = word[31:0] * P1
        OP_M_QUAD,   // h = rotl(h ^ t, 23) * P2 + P3
        OP_M_BYTE,   // t = byte(bidx) * P5
        OP_M_SINGLE, // h = rotl(h ^ t, 11) * P1
        OP_M_AV1,    // h = (h ^ h >> 33) * P2
        OP_M_AV2     // h = (h ^ h >> 29) * P3
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE,
        S_TAKE,
        S_RND_WP2,
        S_RND_LANE,
        S_FIN,
        S_CONV_ADD,
        S_MRG_LP2,
        S_MRG_TR,
        S_MRG_H,
        S_TOTAL,
        S_HLD_CHK,
        S_HLD_WP2,
        S_HLD_TR,
        S_HLD_H,
        S_QUAD_CHK,
        S_QUAD_W,
        S_QUAD_H,
        S_BYTE_CHK,
        S_BYTE_M,
        S_BYTE_H,
        S_AV1,
        S_AV2,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_op        op;
        logic [1:0] sel;   // lane or held word; three picks the input word
        logic [2:0] bidx;  // tail byte index
    } t_cmd;

    typedef struct packed {
        logic       mul_done;
        logic [1:0] hcnt;
        logic [3:0] nbytes;
        logic       last;
        logic       ge32;
        logic       out_full;
    } t_stat;

    function automatic logic [63:0] rotl64(input logic [63:0] v, input int s);
        return (v << s) | (v >> (64 - s));
    endfunction

    function automatic logic is_mul_op(input t_op op);
        logic r;
        case (op) inside
            OP_M_WP2, OP_M_LANE, OP_M_LP2, OP_M_TR, OP_M_MERGE, OP_M_HELD,
            OP_M_W32, OP_M_QUAD, OP_M_BYTE, OP_M_SINGLE, OP_M_AV1,
            OP_M_AV2: r = 1'b1;
            default:  r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/xxh_mul.sv -----
// Low 64 bits of a 64x64 product from one shared 32x32 multiplier, one partial product at a time.
// Depends on nothing outside this file.
`default_nettype none

module xxh_mul (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_a,
    input  wire logic [63:0] i_b,
    output logic             o_done,
    output logic [63:0]      o_prod
);

    logic [63:0] r_a, r_b;
    logic        r_run;
    logic [1:0]  r_phase;
    logic [63:0] r_lo;
    logic [31:0] r_cross;
    logic [63:0] r_prod;
    logic        r_done;

    logic [31:0] ma, mb;
    logic [63:0] pp;

    // Pick the partial product for this phase
    always_comb begin
        case (r_phase)
            2'd0:    begin ma = r_a[31:0];  mb = r_b[31:0];  end
            2'd1:    begin ma = r_a[63:32]; mb = r_b[31:0];  end
            default: begin ma = r_a[31:0];  mb = r_b[63:32]; end
        endcase
    end

    assign pp = 64'(ma) * 64'(mb);

    // Control: run four phases after a start, pulse done once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_phase <= 2'd0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run   <= 1'b1;
                r_phase <= 2'd0;
            end else if (r_run) begin
                r_phase <= r_phase + 2'd1;
                if (r_phase == 2'd3) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Payload: operands, partial sums and the product
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end else if (r_run) begin
            case (r_phase)
                2'd0:    r_lo    <= pp;
                2'd1:    r_cross <= pp[31:0];
                2'd2:    r_cross <= r_cross + pp[31:0];
                default: r_prod  <= r_lo + {r_cross, 32'h0};
            endcase
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ----- hdl/xxh_dp.sv -----
// Datapath of the hasher: lanes, held words, length, working hash and output register.
// Depends on xxh_pkg and xxh_mul.
`default_nettype none

module xxh_dp (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire xxh_pkg::t_cmd  i_cmd,
    input  wire logic [63:0]    i_word_data,
    input  wire logic [3:0]     i_byte_count,
    input  wire logic           i_is_last,
    input  wire logic           i_out_ready,
    output xxh_pkg::t_stat      o_stat,
    output logic                o_out_valid,
    output logic [63:0]         o_hash_value
);

    logic [63:0] r_lane [4];
    logic [63:0] r_held [3];
    logic [1:0]  r_hcnt;
    logic [63:0] r_total;
    logic [63:0] r_w;
    logic [3:0]  r_n;
    logic        r_last;
    logic [63:0] r_h;
    logic [63:0] r_t;
    xxh_pkg::t_op r_pend;
    logic [63:0] r_out;
    logic        r_out_valid;

    logic [63:0] lane_sel;
    logic [63:0] word_sel;
    logic [63:0] hx;
    logic [63:0] byte_sel;
    logic [3:0]  n_eff;
    logic [63:0] mul_a, mul_b;
    logic        mul_start;
    logic        mul_done;
    logic [63:0] mul_prod;

    // Operand selection
    assign lane_sel = r_lane[i_cmd.sel];
    assign word_sel = (i_cmd.sel == xxh_pkg::C_HELD_MAX) ? r_w : r_held[i_cmd.sel];
    assign hx       = r_h ^ r_t;
    assign byte_sel = {56'h0, r_w[{i_cmd.bidx, 3'b000} +: 8]};
    assign n_eff    = !i_is_last ? xxh_pkg::C_WORD_BYTES :
                      (i_byte_count > xxh_pkg::C_WORD_BYTES) ? xxh_pkg::C_WORD_BYTES :
                      i_byte_count;

    // Multiplier operands for each operation
    always_comb begin
        mul_a = 64'h0;
        mul_b = xxh_pkg::C_P1;
        case (i_cmd.op)
            xxh_pkg::OP_M_WP2: begin
                mul_a = word_sel;
                mul_b = xxh_pkg::C_P2;
            end
            xxh_pkg::OP_M_LANE:
                mul_a = xxh_pkg::rotl64(lane_sel + r_t, xxh_pkg::C_ROT_ROUND);
            xxh_pkg::OP_M_LP2: begin
                mul_a = lane_sel;
                mul_b = xxh_pkg::C_P2;
            end
            xxh_pkg::OP_M_TR:     mul_a = xxh_pkg::rotl64(r_t, xxh_pkg::C_ROT_ROUND);
            xxh_pkg::OP_M_MERGE:  mul_a = hx;
            xxh_pkg::OP_M_HELD:   mul_a = xxh_pkg::rotl64(hx, xxh_pkg::C_ROT_HELD);
            xxh_pkg::OP_M_W32:    mul_a = {32'h0, r_w[31:0]};
            xxh_pkg::OP_M_QUAD: begin
                mul_a = xxh_pkg::rotl64(hx, xxh_pkg::C_ROT_QUAD);
                mul_b = xxh_pkg::C_P2;
            end
            xxh_pkg::OP_M_BYTE: begin
                mul_a = byte_sel;
                mul_b = xxh_pkg::C_P5;
            end
            xxh_pkg::OP_M_SINGLE: mul_a = xxh_pkg::rotl64(hx, xxh_pkg::C_ROT_SINGLE);
            xxh_pkg::OP_M_AV1: begin
                mul_a = r_h ^ (r_h >> xxh_pkg::C_SHR_AV1);
                mul_b = xxh_pkg::C_P2;
            end
            xxh_pkg::OP_M_AV2: begin
                mul_a = r_h ^ (r_h >> xxh_pkg::C_SHR_AV2);
                mul_b = xxh_pkg::C_P3;
            end
            default: begin
                mul_a = 64'h0;
                mul_b = xxh_pkg::C_P1;
            end
        endcase
    end

    assign mul_start = xxh_pkg::is_mul_op(i_cmd.op);

    xxh_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    // Control state: lanes, held count, length, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane[0]   <= xxh_pkg::C_LANE0_INIT;
            r_lane[1]   <= xxh_pkg::C_LANE1_INIT;
            r_lane[2]   <= xxh_pkg::C_LANE2_INIT;
            r_lane[3]   <= xxh_pkg::C_LANE3_INIT;
            r_hcnt      <= 2'd0;
            r_total     <= 64'h0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (mul_done && r_pend == xxh_pkg::OP_M_LANE) begin
                r_lane[i_cmd.sel] <= mul_prod;
            end
            case (i_cmd.op)
                xxh_pkg::OP_LOAD: r_total <= r_total + 64'(n_eff);
                xxh_pkg::OP_HOLD: r_hcnt  <= r_hcnt + 2'd1;
                xxh_pkg::OP_SCLR: r_hcnt  <= 2'd0;
                xxh_pkg::OP_EMIT: begin
                    r_out_valid <= 1'b1;
                    r_lane[0]   <= xxh_pkg::C_LANE0_INIT;
                    r_lane[1]   <= xxh_pkg::C_LANE1_INIT;
                    r_lane[2]   <= xxh_pkg::C_LANE2_INIT;
                    r_lane[3]   <= xxh_pkg::C_LANE3_INIT;
                    r_hcnt      <= 2'd0;
                    r_total     <= 64'h0;
                end
                default: ;
            endcase
        end
    end

    // Payload: input word, tail count, held words, working hash, temp and digest
    always_ff @(posedge i_clk) begin
        if (mul_start) begin
            r_pend <= i_cmd.op;
        end
        if (mul_done) begin
            case (r_pend)
                xxh_pkg::OP_M_WP2, xxh_pkg::OP_M_LP2, xxh_pkg::OP_M_TR,
                xxh_pkg::OP_M_W32, xxh_pkg::OP_M_BYTE: r_t <= mul_prod;
                xxh_pkg::OP_M_MERGE, xxh_pkg::OP_M_HELD: r_h <= mul_prod + xxh_pkg::C_P4;
                xxh_pkg::OP_M_QUAD: r_h <= mul_prod + xxh_pkg::C_P3;
                xxh_pkg::OP_M_SINGLE, xxh_pkg::OP_M_AV1,
                xxh_pkg::OP_M_AV2: r_h <= mul_prod;
                default: ;
            endcase
        end
        case (i_cmd.op)
            xxh_pkg::OP_LOAD: begin
                r_w    <= i_word_data;
                r_n    <= n_eff;
                r_last <= i_is_last;
            end
            xxh_pkg::OP_HOLD: begin
                r_held[r_hcnt] <= r_w;
                r_n            <= 4'd0;
            end
            xxh_pkg::OP_SCLR:    r_n <= 4'd0;
            xxh_pkg::OP_H_CONV:  r_h <= xxh_pkg::rotl64(r_lane[0], 1);
            xxh_pkg::OP_H_ADDL: begin
                case (i_cmd.sel)
                    2'd1:    r_h <= r_h + xxh_pkg::rotl64(lane_sel, 7);
                    2'd2:    r_h <= r_h + xxh_pkg::rotl64(lane_sel, 12);
                    default: r_h <= r_h + xxh_pkg::rotl64(lane_sel, 18);
                endcase
            end
            xxh_pkg::OP_H_P5:    r_h <= xxh_pkg::C_P5;
            xxh_pkg::OP_H_TOTAL: r_h <= r_h + r_total;
            xxh_pkg::OP_EMIT:    r_out <= r_h ^ (r_h >> xxh_pkg::C_SHR_AV3);
            default: ;
        endcase
    end

    always_comb begin
        o_stat.mul_done = mul_done;
        o_stat.hcnt     = r_hcnt;
        o_stat.nbytes   = r_n;
        o_stat.last     = r_last;
        o_stat.ge32     = |r_total[63:5];
        o_stat.out_full = r_out_valid;
    end

    assign o_out_valid  = r_out_valid;
    assign o_hash_value = r_out;

endmodule

`default_nettype wire

// ----- hdl/xxh_ctrl.sv -----
// Controller of the hasher: sequences datapath operations for each word and the digest.
// Depends on xxh_pkg.
`default_nettype none

module xxh_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire xxh_pkg::t_stat i_stat,
    output logic                o_in_ready,
    output xxh_pkg::t_cmd       o_cmd
);

    xxh_pkg::t_state r_state, n_state;
    logic            r_busy, n_busy;
    logic [2:0]      r_idx, n_idx;
    logic [3:0]      r_bidx, n_bidx;
    xxh_pkg::t_op    mop;
    logic            mul_fin;

    // State and loop counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= xxh_pkg::S_IDLE;
            r_busy  <= 1'b0;
            r_idx   <= 3'd0;
            r_bidx  <= 4'd0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            r_idx   <= n_idx;
            r_bidx  <= n_bidx;
        end
    end

    assign mul_fin = r_busy && i_stat.mul_done;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_busy     = r_busy;
        n_idx      = r_idx;
        n_bidx     = r_bidx;
        mop        = xxh_pkg::OP_NONE;
        o_in_ready = 1'b0;
        o_cmd.op   = xxh_pkg::OP_NONE;
        o_cmd.sel  = r_idx[1:0];
        o_cmd.bidx = r_bidx[2:0];

        unique case (r_state)
            xxh_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = xxh_pkg::OP_LOAD;
                    n_state  = xxh_pkg::S_TAKE;
                end
            end
            xxh_pkg::S_TAKE: begin
                n_idx = 3'd0;
                if (i_stat.nbytes == xxh_pkg::C_WORD_BYTES) begin
                    if (i_stat.hcnt < xxh_pkg::C_HELD_MAX) begin
                        o_cmd.op = xxh_pkg::OP_HOLD;
                        n_state  = i_stat.last ? xxh_pkg::S_FIN : xxh_pkg::S_IDLE;
                    end else begin
                        n_state = xxh_pkg::S_RND_WP2;
                    end
                end else begin
                    n_state = xxh_pkg::S_FIN;
                end
            end
            xxh_pkg::S_RND_WP2: begin
                mop = xxh_pkg::OP_M_WP2;
                if (mul_fin) n_state = xxh_pkg::S_RND_LANE;
            end
            xxh_pkg::S_RND_LANE: begin
                mop = xxh_pkg::OP_M_LANE;
                if (mul_fin) begin
                    if (r_idx == xxh_pkg::C_LAST_LANE) begin
                        o_cmd.op = xxh_pkg::OP_SCLR;
                        n_idx    = 3'd0;
                        n_state  = i_stat.last ? xxh_pkg::S_FIN : xxh_pkg::S_IDLE;
                    end else begin
                        n_idx   = r_idx + 3'd1;
                        n_state = xxh_pkg::S_RND_WP2;
                    end
                end
            end
            xxh_pkg::S_FIN: begin
                if (i_stat.ge32) begin
                    o_cmd.op = xxh_pkg::OP_H_CONV;
                    n_idx    = 3'd1;
                    n_state  = xxh_pkg::S_CONV_ADD;
                end else begin
                    o_cmd.op = xxh_pkg::OP_H_P5;
                    n_state  = xxh_pkg::S_TOTAL;
                end
            end
            xxh_pkg::S_CONV_ADD: begin
                o_cmd.op = xxh_pkg::OP_H_ADDL;
                if (r_idx == xxh_pkg::C_LAST_LANE) begin
                    n_idx   = 3'd0;
                    n_state = xxh_pkg::S_MRG_LP2;
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end
            xxh_pkg::S_MRG_LP2: begin
                mop = xxh_pkg::OP_M_LP2;
                if (mul_fin) n_state = xxh_pkg::S_MRG_TR;
            end
            xxh_pkg::S_MRG_TR: begin
                mop = xxh_pkg::OP_M_TR;
                if (mul_fin) n_state = xxh_pkg::S_MRG_H;
            end
            xxh_pkg::S_MRG_H: begin
                mop = xxh_pkg::OP_M_MERGE;
                if (mul_fin) begin
                    if (r_idx == xxh_pkg::C_LAST_LANE) begin
                        n_idx   = 3'd0;
                        n_state = xxh_pkg::S_TOTAL;
                    end else begin
                        n_idx   = r_idx + 3'd1;
                        n_state = xxh_pkg::S_MRG_LP2;
                    end
                end
            end
            xxh_pkg::S_TOTAL: begin
                o_cmd.op = xxh_pkg::OP_H_TOTAL;
                n_idx    = 3'd0;
                n_state  = xxh_pkg::S_HLD_CHK;
            end
            xxh_pkg::S_HLD_CHK: begin
                n_state = (r_idx < 3'(i_stat.hcnt)) ? xxh_pkg::S_HLD_WP2
                                                     : xxh_pkg::S_QUAD_CHK;
            end
            xxh_pkg::S_HLD_WP2: begin
                mop = xxh_pkg::OP_M_WP2;
                if (mul_fin) n_state = xxh_pkg::S_HLD_TR;
            end
            xxh_pkg::S_HLD_TR: begin
                mop = xxh_pkg::OP_M_TR;
                if (mul_fin) n_state = xxh_pkg::S_HLD_H;
            end
            xxh_pkg::S_HLD_H: begin
                mop = xxh_pkg::OP_M_HELD;
                if (mul_fin) begin
                    n_idx   = r_idx + 3'd1;
                    n_state = xxh_pkg::S_HLD_CHK;
                end
            end
            xxh_pkg::S_QUAD_CHK: begin
                if (i_stat.nbytes >= xxh_pkg::C_QUAD_BYTES) begin
                    n_bidx  = xxh_pkg::C_QUAD_BYTES;
                    n_state = xxh_pkg::S_QUAD_W;
                end else begin
                    n_bidx  = 4'd0;
                    n_state = xxh_pkg::S_BYTE_CHK;
                end
            end
            xxh_pkg::S_QUAD_W: begin
                mop = xxh_pkg::OP_M_W32;
                if (mul_fin) n_state = xxh_pkg::S_QUAD_H;
            end
            xxh_pkg::S_QUAD_H: begin
                mop = xxh_pkg::OP_M_QUAD;
                if (mul_fin) n_state = xxh_pkg::S_BYTE_CHK;
            end
            xxh_pkg::S_BYTE_CHK: begin
                n_state = (r_bidx < i_stat.nbytes) ? xxh_pkg::S_BYTE_M : xxh_pkg::S_AV1;
            end
            xxh_pkg::S_BYTE_M: begin
                mop = xxh_pkg::OP_M_BYTE;
                if (mul_fin) n_state = xxh_pkg::S_BYTE_H;
            end
            xxh_pkg::S_BYTE_H: begin
                mop = xxh_pkg::OP_M_SINGLE;
                if (mul_fin) begin
                    n_bidx  = r_bidx + 4'd1;
                    n_state = xxh_pkg::S_BYTE_CHK;
                end
            end
            xxh_pkg::S_AV1: begin
                mop = xxh_pkg::OP_M_AV1;
                if (mul_fin) n_state = xxh_pkg::S_AV2;
            end
            xxh_pkg::S_AV2: begin
                mop = xxh_pkg::OP_M_AV2;
                if (mul_fin) n_state = xxh_pkg::S_EMIT;
            end
            xxh_pkg::S_EMIT: begin
                // hold until the previous digest has been taken
                if (!i_stat.out_full) begin
                    o_cmd.op = xxh_pkg::OP_EMIT;
                    n_state  = xxh_pkg::S_IDLE;
                end
            end
            default: n_state = xxh_pkg::S_IDLE;
        endcase

        // Issue the multiply once, then wait for its done pulse
        if (mop != xxh_pkg::OP_NONE) begin
            if (!r_busy) begin
                o_cmd.op = mop;
                n_busy   = 1'b1;
            end else if (i_stat.mul_done) begin
                n_busy = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/xxhash64_stream_hasher_top.sv -----
// XXH64 (seed zero) stream hasher, one 64-bit word per transfer.
// A word that is held passes through the load and hold steps only; a word that completes
// a stripe takes eight 64-bit multiplies on the one shared 32x32 multiplier. The last
// word adds the multiplies of the digest: up to 12 for merging, 3 per held word, 2 for a
// 4-byte chunk, 2 per tail byte, 2 for avalanche. Input is ready only while nothing is in work.
// Reset (synchronous, active low) restores lanes, counts and length; no clearing pass.
`default_nettype none

module xxhash64_stream_hasher_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [63:0] i_word_data,
    input  wire logic [3:0]  i_byte_count,
    input  wire logic        i_is_last,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [63:0]      o_hash_value
);

    xxh_pkg::t_cmd  cmd;
    xxh_pkg::t_stat stat;

    xxh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    xxh_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_word_data  (i_word_data),
        .i_byte_count (i_byte_count),
        .i_is_last    (i_is_last),
        .i_out_ready  (i_out_ready),
        .o_stat       (stat),
        .o_out_valid  (o_out_valid),
        .o_hash_value (o_hash_value)
    );

endmodule

`default_nettype wire

// ----- hdl/xxh_checker.sv -----
// Port-level checks for the hasher top, attached by the bind at the end.
// Depends on assert_macros.svh and xxhash64_stream_hasher_top.
`default_nettype none
`include "assert_macros.svh"

module xxh_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        i_is_last,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [63:0] o_hash_value
);

    logic in_xfer;
    logic word_xfer;
    logic out_xfer;
    logic out_stall;

    // Transfer and stall conditions seen at the ports
    assign in_xfer   = i_in_valid && o_in_ready;
    assign word_xfer = in_xfer && !i_is_last;
    assign out_xfer  = o_out_valid && i_out_ready;
    assign out_stall = o_out_valid && !i_out_ready;

    // Stalled digest holds its value
    property p_out_hold;
        out_stall |=> (o_out_valid && $stable(o_hash_value));
    endproperty

    `XXH_ASSERT(a_out_hold, i_clk, i_rst_n, p_out_hold, "digest dropped or changed while stalled")

    // Reset leaves no digest pending
    `XXH_ASSERT_ALWAYS(a_rst_out, i_clk, !i_rst_n |=> !o_out_valid, "digest valid after reset")

    // One digest per message: no new one straight after a transfer
    `XXH_ASSERT(a_one_digest, i_clk, i_rst_n, out_xfer |=> !o_out_valid, "digest repeated")

    // A word that is not last never brings out a digest
    `XXH_ASSERT(a_no_early, i_clk, i_rst_n, word_xfer |=> !$rose(o_out_valid), "early digest")

    // Not ready again straight after a transfer: busy with the word
    `XXH_ASSERT(a_busy, i_clk, i_rst_n, in_xfer |=> !o_in_ready, "ready after a transfer")

endmodule

bind xxhash64_stream_hasher_top xxh_checker u_xxh_checker (.*);

`default_nettype wire

// ----- sim/xxhash64_stream_hasher_top_tb.sv -----
// Testbench for the XXH64 stream hasher: random and directed messages, each hash
// checked against a predictor built into this file. Depends on xxh_pkg and the top.
`timescale 1ns / 100ps

module xxhash64_stream_hasher_top_tb;

    localparam int STALL_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 1600;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        last;
        logic        drain;   // wait for every owed hash before this transfer
    } t_msg_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [63:0] in_word = '0;
    logic [3:0]  in_nbytes = '0;
    logic        in_last = 1'b0;
    logic        out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [63:0] o_hash_value;

    t_msg_item   pend_q[$];
    logic [63:0] digest_q[$];

    // Predictor state
    logic [63:0] lane_acc[4];
    logic [63:0] stash_words[3];
    int          stash_n;
    logic [63:0] msg_len;

    int items_taken = 0;
    int total_items = 0;
    int digests_sent = 0;
    int digests_seen = 0;
    int err_count = 0;
    int stall_cycles = 0;
    int tx_idle_pct = 16;
    int rx_idle_pct = 50;

    xxhash64_stream_hasher_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_word_data  (in_word),
        .i_byte_count (in_nbytes),
        .i_is_last    (in_last),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_hash_value (o_hash_value)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] rot_left(input logic [63:0] v, input int s);
        if (s == 0)
            return v;
        return (v << s) | (v >> (64 - s));
    endfunction

    function automatic logic [63:0] lane_mix(input logic [63:0] acc, input logic [63:0] w);
        logic [63:0] a;
        a = acc + w * xxh_pkg::C_P2;
        a = rot_left(a, 31);
        return a * xxh_pkg::C_P1;
    endfunction

    task automatic clear_predictor();
        lane_acc[0] = xxh_pkg::C_LANE0_INIT;
        lane_acc[1] = xxh_pkg::C_LANE1_INIT;
        lane_acc[2] = xxh_pkg::C_LANE2_INIT;
        lane_acc[3] = xxh_pkg::C_LANE3_INIT;
        stash_words[0] = '0;
        stash_words[1] = '0;
        stash_words[2] = '0;
        stash_n = 0;
        msg_len = '0;
    endtask

    // Hold a full word, or run the stripe through the lanes once four exist
    task automatic stash_word(input logic [63:0] w);
        if (stash_n < 3) begin
            stash_words[stash_n] = w;
            stash_n++;
        end else begin
            lane_acc[0] = lane_mix(lane_acc[0], stash_words[0]);
            lane_acc[1] = lane_mix(lane_acc[1], stash_words[1]);
            lane_acc[2] = lane_mix(lane_acc[2], stash_words[2]);
            lane_acc[3] = lane_mix(lane_acc[3], w);
            stash_n = 0;
        end
    endtask

    // Advance the predictor by one accepted item; queue the hash on the last one
    task automatic fold_item_into_digest(input t_msg_item it);
        logic [63:0] h;
        int          n;
        int          i;
        if (!it.last) begin
            msg_len += 64'd8;
            stash_word(it.word);
        end else begin
            n = (it.nbytes > 4'd8) ? 8 : int'(it.nbytes);
            msg_len += 64'(n);
            if (n == 8) begin
                stash_word(it.word);
                n = 0;
            end
            if (msg_len >= 64'd32) begin
                h = rot_left(lane_acc[0], 1) + rot_left(lane_acc[1], 7) +
                    rot_left(lane_acc[2], 12) + rot_left(lane_acc[3], 18);
                for (i = 0; i < 4; i++)
                    h = (h ^ lane_mix(64'd0, lane_acc[i])) * xxh_pkg::C_P1 + xxh_pkg::C_P4;
            end else begin
                h = xxh_pkg::C_P5;
            end
            h += msg_len;
            for (i = 0; i < stash_n; i++) begin
                h ^= lane_mix(64'd0, stash_words[i]);
                h = rot_left(h, 27) * xxh_pkg::C_P1 + xxh_pkg::C_P4;
            end
            i = 0;
            if (n >= 4) begin
                h ^= {32'd0, it.word[31:0]} * xxh_pkg::C_P1;
                h = rot_left(h, 23) * xxh_pkg::C_P2 + xxh_pkg::C_P3;
                i = 4;
            end
            for (; i < n; i++) begin
                h ^= {56'd0, it.word[8*i +: 8]} * xxh_pkg::C_P5;
                h = rot_left(h, 11) * xxh_pkg::C_P1;
            end
            h ^= h >> 33;
            h *= xxh_pkg::C_P2;
            h ^= h >> 29;
            h *= xxh_pkg::C_P3;
            h ^= h >> 32;
            digest_q.push_back(h);
            digests_sent++;
            clear_predictor();
        end
    endtask

    task automatic flag_error(input string what, input logic [63:0] want,
                              input logic [63:0] got);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("ERROR %s: expected %h, got %h", what, want, got);
    endtask

    function automatic logic [63:0] rand_word();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return {$urandom(), $urandom()};
    endfunction

    task automatic queue_item(input logic [63:0] w, input logic [3:0] nb,
                              input logic last, input logic drain);
        t_msg_item it;
        it.word = w;
        it.nbytes = nb;
        it.last = last;
        it.drain = drain;
        pend_q.push_back(it);
    endtask

    // Queue a message of full words then one last item; non-last counts are junk
    task automatic queue_msg(input int nfull, input logic [3:0] last_nb,
                             input logic drain);
        int k;
        for (k = 0; k < nfull; k++)
            queue_item(rand_word(), 4'($urandom_range(0, 15)), 1'b0, drain && k == 0);
        queue_item(rand_word(), last_nb, 1'b1, drain && nfull == 0);
    endtask

    // Drive items: hold valid until the transfer, then pick the next item
    always @(posedge i_clk) begin : drive_proc
        logic      nxt_valid;
        t_msg_item it;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            nxt_valid = in_valid;
            if (in_valid && o_in_ready) begin
                it = pend_q.pop_front();
                fold_item_into_digest(it);
                items_taken++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && pend_q.size() > 0) begin
                it = pend_q[0];
                if (!(it.drain && digests_sent != digests_seen) &&
                    $urandom_range(0, 99) >= tx_idle_pct) begin
                    nxt_valid = 1'b1;
                    in_word <= it.word;
                    in_nbytes <= it.nbytes;
                    in_last <= it.last;
                end
            end
            in_valid <= nxt_valid;
            // Swap idling between the sides, then drop it altogether
            if (items_taken < total_items / 3) begin
                tx_idle_pct <= 16;
                rx_idle_pct <= 50;
            end else if (items_taken < (2 * total_items) / 3) begin
                tx_idle_pct <= 50;
                rx_idle_pct <= 16;
            end else begin
                tx_idle_pct <= 0;
                rx_idle_pct <= 0;
            end
        end
    end

    // Check each hash transfer against the oldest owed digest
    always @(posedge i_clk) begin : check_proc
        logic [63:0] want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                digests_seen <= digests_seen + 1;
                if (digest_q.size() == 0) begin
                    flag_error("unexpected hash", 64'd0, o_hash_value);
                end else begin
                    want = digest_q.pop_front();
                    if (o_hash_value !== want)
                        flag_error("hash_value", want, o_hash_value);
                end
            end
            out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Watchdog: end the run if transfers stop for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("xxhash64_stream_hasher_top: mismatch");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int nfull;
        int k;
        logic [3:0] last_nb;
        clear_predictor();

        // Directed: empty message, short tails, saturating count, stripe edges
        queue_item('1, 4'd0, 1'b1, 1'b0);
        queue_item(rand_word(), 4'd1, 1'b1, 1'b0);
        queue_item('1, 4'd4, 1'b1, 1'b0);
        queue_item(64'h0123_4567_89AB_CDEF, 4'd7, 1'b1, 1'b0);
        queue_item('1, 4'd15, 1'b1, 1'b0);
        queue_item('0, 4'd0, 1'b0, 1'b0);
        queue_item('1, 4'd15, 1'b0, 1'b0);
        queue_item('0, 4'd8, 1'b0, 1'b0);
        queue_item('1, 4'd8, 1'b1, 1'b0);
        queue_msg(3, 4'd0, 1'b0);
        queue_msg(4, 4'd5, 1'b0);
        queue_msg(5, 4'd11, 1'b0);

        // Random messages, mostly short, a few long; hold off now and then
        k = 0;
        while (pend_q.size() < RANDOM_ITEMS + 24) begin
            nfull = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                : $urandom_range(0, 9);
            last_nb = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                  : 4'($urandom_range(0, 8));
            queue_msg(nfull, last_nb, k == 0 || $urandom_range(0, 29) == 0);
            k++;
        end
        total_items = pend_q.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the stimulus to drain and every hash to arrive
        do
            @(negedge i_clk);
        while (pend_q.size() != 0 || in_valid || digests_seen != digests_sent);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (digest_q.size() != 0)
            flag_error("missing hash", digest_q[0], 64'd0);

        if (err_count == 0)
            $display("xxhash64_stream_hasher_top: match");
        else
            $display("xxhash64_stream_hasher_top: mismatch");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/xxh_pkg.sv
hdl/xxh_mul.sv
hdl/xxh_dp.sv
hdl/xxh_ctrl.sv
hdl/xxhash64_stream_hasher_top.sv
hdl/xxh_checker.sv
sim/xxhash64_stream_hasher_top_tb.sv
